// File: rtl/core/amms_pkg.sv
// Shared constants and types for the set statistics block.
`timescale 1ns / 1ps
package amms_pkg;
   localparam int MAX_SAMPLES = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + CNT_BITS;
   localparam int MEAN_BITS   = 24;
   localparam int SD_BITS     = 23;
   localparam int SQ_BITS     = 64;
   localparam int DIV_BITS    = 64;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
endpackage

// File: rtl/core/amms_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
`timescale 1ns / 1ps
module amms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/amms_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module amms_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [amms_pkg::DIV_BITS-1:0] dividend,
   input  logic [amms_pkg::CNT_BITS-1:0] divisor,
   output logic                          done,
   output logic [amms_pkg::DIV_BITS-1:0] quotient
);
   localparam int DB = amms_pkg::DIV_BITS;
   localparam int RB = amms_pkg::CNT_BITS + 1;
   logic [DB-1:0]         q_ff;
   logic [RB-1:0]         r_ff;
   logic [$clog2(DB)-1:0] n_ff;
   logic                  run_ff, done_ff;
   logic [RB-1:0]         trial;
   logic [RB-1:0]         dv;

   assign dv    = {1'b0, divisor};
   assign trial = {r_ff[RB-2:0], q_ff[DB-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            q_ff   <= dividend;
            r_ff   <= '0;
            n_ff   <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (trial >= dv) begin
               r_ff <= trial - dv;
               q_ff <= {q_ff[DB-2:0], 1'b1};
            end else begin
               r_ff <= trial;
               q_ff <= {q_ff[DB-2:0], 1'b0};
            end
            n_ff <= n_ff + 1'b1;
            if (n_ff == $clog2(DB)'(DB - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

// File: rtl/core/array_min_max_mean_stddev_top.sv
// Top level of the set statistics block: sample load, closing pass, divide and root.
`timescale 1ns / 1ps
// Set statistics: min, max, Q8 mean and Q8 population standard deviation.
// Input: pulse start with req_sample/req_last while busy is low; that is one
//   transfer. After a sample transfer that is not last, busy stays low.
// The last sample of a set starts the closing sequence; busy stays high until
//   the result strobe has passed:
//   mean divide (launch, quotient bits, done) on the shared divider,
//   squares pass over the sample RAM (one read per cycle),
//   variance divide, integer root (one root bit per step),
//   then the result is registered.
//   busy drops in the cycle after the rsp_valid strobe.
// Output: rsp_valid is high for exactly one cycle with all rsp_ fields; the
//   receiver cannot stall, so the result is never held.
// Samples past 256 are dropped (also a final one) and rsp_overflow is set.
// Reset (synchronous, active high) clears the set state and the sequencer;
//   the sample RAM is not cleared, only entries of the current set are read.
module array_min_max_mean_stddev_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [amms_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic signed [amms_pkg::SAMPLE_BITS-1:0] rsp_minimum,
   output logic signed [amms_pkg::SAMPLE_BITS-1:0] rsp_maximum,
   output logic signed [amms_pkg::MEAN_BITS-1:0]   rsp_mean_q8,
   output logic [amms_pkg::SD_BITS-1:0]        rsp_stddev_q8,
   output logic [amms_pkg::CNT_BITS-1:0]       rsp_sample_count,
   output logic                                rsp_overflow
);
   localparam int SB = amms_pkg::SAMPLE_BITS;
   localparam int AB = amms_pkg::ADDR_BITS;
   localparam int CB = amms_pkg::CNT_BITS;
   localparam int UB = amms_pkg::SUM_BITS;
   localparam int QB = amms_pkg::SQ_BITS;
   localparam int DB = SB + 10; // Q8 difference magnitude

   typedef enum logic [2:0] {
      S_LOAD, S_MDIV, S_MWAIT, S_PASS, S_VDIV, S_VWAIT, S_ROOT, S_OUT
   } state_type;

   state_type state_ff;
   logic [CB-1:0]       cnt_ff;
   logic signed [SB-1:0] min_ff, max_ff;
   logic signed [UB-1:0] sum_ff;
   logic                ovf_ff;
   logic signed [amms_pkg::MEAN_BITS+1:0] mean_ff;
   logic                neg_ff;
   logic [CB-1:0]       rd_ff;       // next read address counter
   logic [CB-1:0]       got_ff;      // reads returned
   logic                rv_ff;       // read data valid in this cycle
   logic [2*DB-1:0]     sqr_ff;      // registered square
   logic                sqv_ff;
   logic [QB-1:0]       acc_ff;
   logic [QB-1:0]       rem_ff;
   logic [QB-1:0]       res_ff;      // partial root, scaled by the current bit
   logic [4:0]          step_ff;
   logic [amms_pkg::SD_BITS-1:0] sd_ff;
   logic                rsp_ff;

   logic                accept, store_it;
   logic signed [SB-1:0] rd_data;
   logic                div_go, div_done;
   logic [QB-1:0]       div_a, div_q;
   logic [UB+7:0]       mag;
   logic signed [DB:0]  diff;
   logic [DB-1:0]       ad;
   logic [QB-1:0]       bit_v, tr;

   assign accept   = start && !busy;
   assign store_it = accept && (cnt_ff < CB'(amms_pkg::MAX_SAMPLES));
   // busy covers the strobe cycle too: the set state clears at its end
   assign busy     = (state_ff != S_LOAD) || rsp_ff;

   amms_ram #(.WIDTH(SB), .DEPTH(amms_pkg::MAX_SAMPLES)) u_ram (
      .clock  (clock),
      .wr_en  (store_it),
      .wr_addr(cnt_ff[AB-1:0]),
      .wr_data(req_sample),
      .rd_addr(rd_ff[AB-1:0]),
      .rd_data(rd_data)
   );

   // Rounded magnitude of sum*256 for the mean divide.
   assign mag = (sum_ff < 0) ? {(-sum_ff), 8'd0} : {sum_ff, 8'd0};
   assign div_go = (state_ff == S_MDIV) || (state_ff == S_VDIV);
   assign div_a  = (state_ff == S_MDIV) ? QB'(mag) + QB'(cnt_ff >> 1) : acc_ff;

   amms_div u_div (
      .clock   (clock),
      .reset   (reset),
      .go      (div_go),
      .dividend(div_a),
      .divisor (cnt_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   assign diff  = (DB+1)'($signed({rd_data, 8'd0})) - (DB+1)'(mean_ff);
   assign ad    = diff[DB] ? DB'(-diff) : DB'(diff);
   assign bit_v = QB'(1) << {step_ff, 1'b0};
   assign tr    = res_ff + bit_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         rsp_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         sqv_ff   <= 1'b0;
      end else begin
         rsp_ff <= 1'b0;
         case (state_ff)
            S_LOAD: begin
               if (store_it) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  sum_ff <= sum_ff + UB'(req_sample);
                  if (cnt_ff == '0 || req_sample < min_ff) min_ff <= req_sample;
                  if (cnt_ff == '0 || req_sample > max_ff) max_ff <= req_sample;
               end else if (accept) begin
                  ovf_ff <= 1'b1;
               end
               if (accept && req_last) state_ff <= S_MDIV;
            end
            S_MDIV: begin
               neg_ff   <= (sum_ff < 0);
               state_ff <= S_MWAIT;
            end
            S_MWAIT: begin
               if (div_done) begin
                  mean_ff  <= neg_ff ? -($bits(mean_ff))'(div_q) : ($bits(mean_ff))'(div_q);
                  rd_ff    <= '0;
                  got_ff   <= '0;
                  acc_ff   <= '0;
                  rv_ff    <= 1'b0;
                  sqv_ff   <= 1'b0;
                  state_ff <= S_PASS;
               end
            end
            S_PASS: begin
               // read, square (registered), accumulate
               rv_ff <= (rd_ff < cnt_ff);
               if (rd_ff < cnt_ff) rd_ff <= rd_ff + 1'b1;
               sqv_ff <= rv_ff;
               if (rv_ff) sqr_ff <= ad * ad;
               if (sqv_ff) begin
                  acc_ff <= acc_ff + QB'(sqr_ff);
                  got_ff <= got_ff + 1'b1;
                  if (got_ff + 1'b1 == cnt_ff) state_ff <= S_VDIV;
               end
            end
            S_VDIV: state_ff <= S_VWAIT;
            S_VWAIT: begin
               if (div_done) begin
                  rem_ff   <= div_q;
                  res_ff   <= '0;
                  step_ff  <= 5'd31;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               // bitwise root, one result bit per cycle
               if (rem_ff >= tr) begin
                  rem_ff <= rem_ff - tr;
                  res_ff <= (res_ff >> 1) + bit_v;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               if (step_ff == '0) state_ff <= S_OUT;
               else step_ff <= step_ff - 1'b1;
            end
            S_OUT: begin
               sd_ff    <= res_ff[amms_pkg::SD_BITS-1:0];
               rsp_ff   <= 1'b1;
               state_ff <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
         if (rsp_ff) begin
            cnt_ff <= '0;
            sum_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   // Result held during the strobe cycle; set state clears after it.
   assign rsp_valid        = rsp_ff;
   assign rsp_minimum      = min_ff;
   assign rsp_maximum      = max_ff;
   assign rsp_mean_q8      = mean_ff[amms_pkg::MEAN_BITS-1:0];
   assign rsp_stddev_q8    = sd_ff;
   assign rsp_sample_count = cnt_ff;
   assign rsp_overflow     = ovf_ff;
endmodule

// File: tb/tb.sv
// Testbench for the set statistics block: directed and random sets checked against a predictor.
`timescale 1ns / 1ps
// Sample transfers are queued by an initial block and sent by a clocked driver
// with random idle bursts. A clocked monitor folds each accepted sample into a
// shadow of the set state. On each last sample it predicts min, max, Q8 mean
// and Q8 population stddev, then checks every rsp_valid strobe against the
// oldest prediction.
module tb;
   localparam int STALL_LIMIT = 5000;   // watchdog limit on cycles with no transfer and no result

   typedef struct {
      amms_pkg::sample_type smp;
      logic       fin;
      int         gap;                  // idle cycles before this transfer
   } sample_xfer_type;

   typedef struct {
      logic signed [amms_pkg::SAMPLE_BITS-1:0] lo;
      logic signed [amms_pkg::SAMPLE_BITS-1:0] hi;
      logic signed [amms_pkg::MEAN_BITS-1:0]   mean;
      logic [amms_pkg::SD_BITS-1:0]            sd;
      logic [amms_pkg::CNT_BITS-1:0]           cnt;
      logic                                    ovf;
   } set_stats_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   amms_pkg::sample_type          req_sample = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic signed [amms_pkg::SAMPLE_BITS-1:0] rsp_minimum;
   logic signed [amms_pkg::SAMPLE_BITS-1:0] rsp_maximum;
   logic signed [amms_pkg::MEAN_BITS-1:0]   rsp_mean_q8;
   logic [amms_pkg::SD_BITS-1:0]            rsp_stddev_q8;
   logic [amms_pkg::CNT_BITS-1:0]           rsp_sample_count;
   logic                          rsp_overflow;

   sample_xfer_type pending_samples[$];
   set_stats_type   stats_expected[$];
   int           mismatches = 0;
   int           sets_checked = 0;
   int           samples_sent = 0;
   int           idle_cycles = 0;
   int           quiet_cycles = 0;
   bit           allow_gaps = 1'b1;

   // shadow of the set state inside the block
   longint set_vals[$];
   longint run_min, run_max, run_sum;
   bit     run_ovf = 1'b0;

   array_min_max_mean_stddev_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_minimum(rsp_minimum),
      .rsp_maximum(rsp_maximum), .rsp_mean_q8(rsp_mean_q8),
      .rsp_stddev_q8(rsp_stddev_q8), .rsp_sample_count(rsp_sample_count),
      .rsp_overflow(rsp_overflow)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t: set %0d %s got %0d want %0d", $time, sets_checked, what, got, want);
   endtask

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   // Fold one accepted sample; on the last one, push the predicted statistics.
   task automatic fold_sample(input amms_pkg::sample_type smp, input logic fin);
      longint          s, c, mean, d;
      longint unsigned acc;
      set_stats_type   st;
      s = longint'(smp);
      if (set_vals.size() < amms_pkg::MAX_SAMPLES) begin
         if (set_vals.size() == 0) begin
            run_min = s;
            run_max = s;
            run_sum = 0;
         end else begin
            if (s < run_min) run_min = s;
            if (s > run_max) run_max = s;
         end
         run_sum += s;
         set_vals.push_back(s);
      end else begin
         run_ovf = 1'b1;
      end
      if (!fin) return;
      c = set_vals.size();
      // round to nearest, ties away from zero
      if (run_sum >= 0) mean = ((run_sum * 256) + c / 2) / c;
      else mean = -(((-run_sum) * 256 + c / 2) / c);
      acc = 0;
      foreach (set_vals[i]) begin
         d = set_vals[i] * 256 - mean;
         if (d < 0) d = -d;
         acc += longint'(d) * longint'(d);
      end
      st.lo   = run_min[amms_pkg::SAMPLE_BITS-1:0];
      st.hi   = run_max[amms_pkg::SAMPLE_BITS-1:0];
      st.mean = mean[amms_pkg::MEAN_BITS-1:0];
      st.sd   = amms_pkg::SD_BITS'(floor_root(acc / c));
      st.cnt  = c[amms_pkg::CNT_BITS-1:0];
      st.ovf  = run_ovf;
      stats_expected.push_back(st);
      set_vals.delete();
      run_ovf = 1'b0;
   endtask

   // Driver: hold the transfer until accepted, then apply the next one's gap.
   always @(posedge clock) begin
      logic            nxt_start;
      sample_xfer_type it;
      nxt_start = start;
      if (!reset && !(start && busy)) begin
         nxt_start = 1'b0;
         if (idle_cycles > 0) begin
            idle_cycles--;
         end else if (pending_samples.size() > 0) begin
            if (pending_samples[0].gap > 0) begin
               idle_cycles = pending_samples[0].gap - 1;
               pending_samples[0].gap = 0;
            end else begin
               it = pending_samples.pop_front();
               req_sample <= it.smp;
               req_last   <= it.fin;
               nxt_start  = 1'b1;
            end
         end
      end
      start <= nxt_start;
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      set_stats_type want;
      if (!reset) begin
         quiet_cycles++;
         if (start && !busy) begin
            quiet_cycles = 0;
            samples_sent++;
            fold_sample(req_sample, req_last);
         end
         if (rsp_valid) begin
            quiet_cycles = 0;
            if (stats_expected.size() == 0) begin
               report_mismatch("unexpected result, count", rsp_sample_count, 0);
            end else begin
               want = stats_expected.pop_front();
               if (rsp_minimum !== want.lo) report_mismatch("minimum", rsp_minimum, want.lo);
               if (rsp_maximum !== want.hi) report_mismatch("maximum", rsp_maximum, want.hi);
               if (rsp_mean_q8 !== want.mean) report_mismatch("mean_q8", rsp_mean_q8, want.mean);
               if (rsp_stddev_q8 !== want.sd) report_mismatch("stddev_q8", rsp_stddev_q8, want.sd);
               if (rsp_sample_count !== want.cnt)
                  report_mismatch("sample_count", rsp_sample_count, want.cnt);
               if (rsp_overflow !== want.ovf) report_mismatch("overflow", rsp_overflow, want.ovf);
            end
            sets_checked++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic queue_sample(input longint v, input bit fin);
      sample_xfer_type it;
      it.smp = v[amms_pkg::SAMPLE_BITS-1:0];
      it.fin = fin;
      it.gap = (allow_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      pending_samples.push_back(it);
   endtask

   // A whole set of n samples drawn from [lo, hi].
   task automatic queue_set(input int n, input longint lo, input longint hi);
      for (int i = 0; i < n; i++)
         queue_sample(lo + longint'($urandom_range(0, int'(hi - lo))), i == n - 1);
   endtask

   initial begin
      int n, mode, queued;
      // directed: extremes, sign of the mean, rounding, capacity edges
      queue_sample(32767, 1);
      queue_sample(-32768, 1);
      queue_sample(-32768, 0); queue_sample(32767, 1);
      queue_sample(1, 0); queue_sample(0, 0); queue_sample(0, 1);     // mean rounds down
      queue_sample(-1, 0); queue_sample(0, 0); queue_sample(0, 1);    // negative rounding
      queue_sample(2, 0); queue_sample(2, 0); queue_sample(2, 1);     // zero spread
      // full store, then two dropped samples including the last one
      queue_set(amms_pkg::MAX_SAMPLES + 2, -32768, 32767);
      // random sets: mostly short, some longer, mixed value ranges
      queued = 0;
      while (queued < 230) begin
         if (queued > 180) allow_gaps = 1'b0;
         mode = $urandom_range(0, 9);
         n = (mode == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         case ($urandom_range(0, 2))
            0: queue_set(n, -32768, 32767);
            1: queue_set(n, -40, 40);
            default: queue_set(n, 32000, 32767);
         endcase
         queued += n;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_samples.size() != 0 || start || stats_expected.size() != 0);
      repeat (600) begin
         @(posedge clock);
      end
      $display("Sent %0d samples, checked %0d set results (capacity and overflow sets included).",
               samples_sent, sets_checked);
      if (mismatches == 0 && stats_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
